>>> sv/tcd_pkg.sv
package tcd_pkg;

  localparam int unsigned HeaderLen   = 18;
  localparam int unsigned MaxWidth    = 1024;
  localparam int unsigned MaxHeight   = 512;
  localparam int unsigned PaletteSize = 256;
  localparam int unsigned SectorLimit = 2048;

  localparam logic [0:0] REG_SECTOR_SIZE = 1'b0;
  localparam logic [0:0] REG_FILE_SIZE   = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACCEPT  = 2'd0,
    KIND_PALETTE = 2'd1,
    KIND_PIXEL   = 2'd2,
    KIND_REJECT  = 2'd3
  } kind_t;

  localparam logic [2:0] ERR_TYPE         = 3'd0;
  localparam logic [2:0] ERR_PAL_LENGTH   = 3'd1;
  localparam logic [2:0] ERR_ENTRY_SIZE   = 3'd2;
  localparam logic [2:0] ERR_IMAGE_SIZE   = 3'd3;
  localparam logic [2:0] ERR_PAST_SECTOR  = 3'd4;
  localparam logic [2:0] ERR_PAST_FILE    = 3'd5;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_SKIP_ID = 5'b00010,
    PH_PALETTE = 5'b00100,
    PH_PIXELS  = 5'b01000,
    PH_IDLE    = 5'b10000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  error_code;
    logic [7:0]  palette_index;
    logic [4:0]  red;
    logic [4:0]  green;
    logic [4:0]  blue;
    logic        opaque;
    logic [9:0]  column;
    logic [8:0]  row;
    logic [10:0] image_width;
    logic [9:0]  image_height;
    logic        image_done;
  } result_t;

endpackage

>>> sv/tcd_if.sv
interface tcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       first_of_file;
  modport source (output valid, output byte_value, output first_of_file, input ready);
  modport sink (input valid, input byte_value, input first_of_file, output ready);
endinterface

interface tcd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  error_code;
  logic [7:0]  palette_index;
  logic [4:0]  red;
  logic [4:0]  green;
  logic [4:0]  blue;
  logic        opaque;
  logic [9:0]  column;
  logic [8:0]  row;
  logic [10:0] image_width;
  logic [9:0]  image_height;
  logic        image_done;
  modport source (output valid, output kind, output error_code, output palette_index,
                  output red, output green, output blue, output opaque, output column,
                  output row, output image_width, output image_height,
                  output image_done, input ready);
  modport sink (input valid, input kind, input error_code, input palette_index,
                input red, input green, input blue, input opaque, input column,
                input row, input image_width, input image_height, input image_done,
                output ready);
endinterface

interface tcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [19:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/tcd_parser.sv
module tcd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       byte_value,
  input  logic             first_of_file,
  input  logic [11:0]      sector_size,
  input  logic [19:0]      file_size,
  output logic             push,
  output tcd_pkg::result_t result
);
  import tcd_pkg::*;

  phase_t      phase;
  logic [4:0]  hpos;
  logic [7:0]  hdr [HeaderLen];
  logic [20:0] area;
  logic [10:0] pixoff;
  logic [8:0]  pal_count;
  logic        four;
  logic [10:0] width_h;
  logic [9:0]  height_h;
  logic        top_down;
  logic [9:0]  hold;
  logic [8:0]  cnt;
  logic [1:0]  sub;
  logic [9:0]  col;
  logic [8:0]  row;

  phase_t      cur_phase;
  logic [4:0]  cur_pos;
  logic [15:0] cmaplen, w, h;
  logic [12:0] ss;
  logic [21:0] pix_end;
  logic        header_ok;
  logic [2:0]  err;
  logic        last_col, last_row, last_sub;
  logic [9:0]  mirrored;

  assign cur_phase = first_of_file ? PH_HEADER : phase;
  assign cur_pos   = first_of_file ? 5'd0 : hpos;
  assign cmaplen   = {hdr[6], hdr[5]};
  assign w         = {hdr[13], hdr[12]};
  assign h         = {hdr[15], hdr[14]};
  assign ss        = (sector_size == 12'd0) ? 13'(SectorLimit) : {1'b0, sector_size};
  assign pix_end   = 22'(pixoff) + 22'(area);
  assign last_col  = (11'(col) + 11'd1) >= width_h;
  assign last_row  = (10'(row) + 10'd1) >= height_h;
  assign last_sub  = (sub == (four ? 2'd3 : 2'd2));
  assign mirrored  = height_h - 10'd1 - 10'(row);

  // Header checks run in order of their error codes; the first failure wins.
  always_comb begin
    header_ok = 1'b0;
    err       = ERR_TYPE;
    priority if (hdr[1] != 8'd1 || hdr[2] != 8'd1 || hdr[16] != 8'd8) err = ERR_TYPE;
    else if (cmaplen == 16'd0 || cmaplen > 16'(PaletteSize)) err = ERR_PAL_LENGTH;
    else if (hdr[7] != 8'd24 && hdr[7] != 8'd32) err = ERR_ENTRY_SIZE;
    else if (w == 16'd0 || h == 16'd0 || w > 16'(MaxWidth) || h > 16'(MaxHeight))
      err = ERR_IMAGE_SIZE;
    else if (ss > 13'(SectorLimit) || 13'(pixoff) > ss) err = ERR_PAST_SECTOR;
    else if (pix_end > 22'(file_size)) err = ERR_PAST_FILE;
    else header_ok = 1'b1;
  end

  always_comb begin
    push   = 1'b0;
    result = '0;
    unique case (cur_phase)
      PH_HEADER: begin
        if (cur_pos == 5'(HeaderLen - 1)) begin
          push = accept;
          if (header_ok) begin
            result.kind         = KIND_ACCEPT;
            result.image_width  = w[10:0];
            result.image_height = h[9:0];
          end else begin
            result.kind       = KIND_REJECT;
            result.error_code = err;
          end
        end
      end
      PH_PALETTE: begin
        if (sub == 2'd2) begin
          push                 = accept;
          result.kind          = KIND_PALETTE;
          result.palette_index = cnt[7:0];
          result.red           = byte_value[7:3];
          result.green         = hold[9:5];
          result.blue          = hold[4:0];
          result.opaque        = (cnt != 9'd0);
        end
      end
      PH_PIXELS: begin
        push                 = accept;
        result.kind          = KIND_PIXEL;
        result.palette_index = byte_value;
        result.column        = col;
        result.row           = top_down ? row : mirrored[8:0];
        result.image_done    = last_col && last_row;
      end
      PH_SKIP_ID, PH_IDLE: ;
      default: ;
    endcase
  end

  // Header store holds payload only; no reset needed.
  always_ff @(posedge clk) begin
    if (accept && cur_phase == PH_HEADER) begin
      hdr[cur_pos] <= byte_value;
      // Pixel count and pixel offset are formed on earlier header bytes so the
      // last byte only needs one add and the compares.
      if (cur_pos == 5'd15) area <= 21'(w[10:0]) * 21'({byte_value[1:0], hdr[14]});
      if (cur_pos == 5'd16) begin
        pixoff <= 11'(HeaderLen) + 11'(hdr[0]) +
                  ((hdr[7] == 8'd32) ? {cmaplen[8:0], 2'b00} : 11'(cmaplen[8:0]) * 11'd3);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      hpos      <= '0;
      pal_count <= '0;
      four      <= 1'b0;
      width_h   <= '0;
      height_h  <= '0;
      top_down  <= 1'b0;
      hold      <= '0;
      cnt       <= '0;
      sub       <= '0;
      col       <= '0;
      row       <= '0;
    end else if (accept) begin
      unique case (cur_phase)
        PH_HEADER: begin
          hpos  <= cur_pos + 5'd1;
          phase <= PH_HEADER;
          if (cur_pos == 5'(HeaderLen - 1)) begin
            if (header_ok) begin
              pal_count <= cmaplen[8:0];
              four      <= (hdr[7] == 8'd32);
              width_h   <= w[10:0];
              height_h  <= h[9:0];
              top_down  <= byte_value[5];
              cnt       <= '0;
              sub       <= '0;
              col       <= '0;
              row       <= '0;
              phase     <= (hdr[0] != 8'd0) ? PH_SKIP_ID : PH_PALETTE;
            end else begin
              phase <= PH_IDLE;
            end
          end
        end
        PH_SKIP_ID: begin
          if ((cnt + 9'd1) >= 9'(hdr[0])) begin
            cnt   <= '0;
            phase <= PH_PALETTE;
          end else begin
            cnt <= cnt + 9'd1;
          end
        end
        PH_PALETTE: begin
          if (sub == 2'd0) hold <= {5'd0, byte_value[7:3]};
          else if (sub == 2'd1) hold <= {byte_value[7:3], hold[4:0]};
          if (last_sub) begin
            sub <= '0;
            if ((cnt + 9'd1) >= pal_count) begin
              cnt   <= '0;
              phase <= PH_PIXELS;
            end else begin
              cnt <= cnt + 9'd1;
            end
          end else begin
            sub <= sub + 2'd1;
          end
        end
        PH_PIXELS: begin
          if (last_col) begin
            col <= '0;
            if (last_row) phase <= PH_IDLE;
            else row <= row + 9'd1;
          end else begin
            col <= col + 10'd1;
          end
        end
        PH_IDLE: ;
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

>>> sv/tcd_queue.sv
module tcd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tcd_pkg::result_t push_data,
  output logic             space,
  input  logic             pop,
  output logic             valid,
  output tcd_pkg::result_t head
);
  import tcd_pkg::*;

  result_t    mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign space = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> sv/tga_colormapped_image_decoder_unit.sv
// Streaming decoder for colour-mapped, uncompressed, 8-bit TGA files. Bytes enter one per
// cycle on the stream channel; first_of_file restarts parsing. On the 18th header byte one
// accept or reject item comes out, then one item per palette entry (on its red byte) and
// one per pixel. The parser takes a byte every cycle unless stalled. A two-entry result
// queue between the parser and the result port stalls the stream only when it is full. The
// user must write sector_size and file_size on the cfg channel only while no file is being
// decoded; the block does not enforce it. Both are sampled on the last header byte.
module tga_colormapped_image_decoder_unit (
  input logic          clk,
  input logic          rst,
  tcd_byte_if.sink     stream,
  tcd_cfg_if.sink      cfg,
  tcd_result_if.source results
);
  import tcd_pkg::*;

  logic [11:0] sector_size;
  logic [19:0] file_size;
  logic        accept, push, space, pop;
  result_t     res, head;

  assign cfg.ready    = 1'b1;
  assign stream.ready = space;
  assign accept       = stream.valid && space;
  assign pop          = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_size <= 12'(SectorLimit);
      file_size   <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SECTOR_SIZE: sector_size <= cfg.data[11:0];
        REG_FILE_SIZE:   file_size   <= cfg.data;
        default: ;
      endcase
    end
  end

  tcd_parser u_parser (
    .clk(clk), .rst(rst), .accept(accept), .byte_value(stream.byte_value),
    .first_of_file(stream.first_of_file), .sector_size(sector_size),
    .file_size(file_size), .push(push), .result(res)
  );

  tcd_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(res), .space(space),
    .pop(pop), .valid(results.valid), .head(head)
  );

  assign results.kind          = head.kind;
  assign results.error_code    = head.error_code;
  assign results.palette_index = head.palette_index;
  assign results.red           = head.red;
  assign results.green         = head.green;
  assign results.blue          = head.blue;
  assign results.opaque        = head.opaque;
  assign results.column        = head.column;
  assign results.row           = head.row;
  assign results.image_width   = head.image_width;
  assign results.image_height  = head.image_height;
  assign results.image_done    = head.image_done;

endmodule

>>> sv/tcd_checker.sv
module tcd_checker (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic [1:0] kind,
  input logic [2:0] error_code,
  input logic [7:0] palette_index,
  input logic       opaque,
  input logic       image_done
);
  import tcd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(kind))
    else $error("result item dropped while stalled");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    valid && kind == KIND_REJECT |-> error_code <= ERR_PAST_FILE)
    else $error("reject code out of range");

  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    valid && kind != KIND_REJECT |-> error_code == 3'd0)
    else $error("error code on a non-reject item");

  a_opaque: assert property (@(posedge clk) disable iff (rst)
    valid && kind == KIND_PALETTE |-> opaque == (palette_index != 8'd0))
    else $error("palette transparency wrong");

  a_done: assert property (@(posedge clk) disable iff (rst)
    valid && image_done |-> kind == KIND_PIXEL)
    else $error("image done on a non-pixel item");

endmodule

bind tga_colormapped_image_decoder_unit tcd_checker u_tcd_checker (
  .clk(clk), .rst(rst), .valid(results.valid), .ready(results.ready),
  .kind(results.kind), .error_code(results.error_code),
  .palette_index(results.palette_index), .opaque(results.opaque),
  .image_done(results.image_done)
);
